@@ src/ctsf_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsf_pkg
// Shared types and constants for the cache tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ctsf_pkg;

    localparam int NUM_LINES = 256;
    localparam int LINE_AW   = 8;     // log2 of NUM_LINES
    localparam int CNT_W     = 9;     // holds 0..NUM_LINES
    localparam int ADDR_W    = 31;
    localparam int TAG_W     = 31;
    localparam int RANK_W    = 8;
    localparam int LB_W      = 4;

    // associativity codes
    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_SET4   = 2'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_ASSOC  = 3'd0;
    localparam logic [2:0] CFG_POLICY = 3'd1;
    localparam logic [2:0] CFG_OFFSET = 3'd2;
    localparam logic [2:0] CFG_LINES  = 3'd3;

    localparam logic [LB_W-1:0] LB_MIN     = 4'd2;
    localparam logic [LB_W-1:0] LB_MAX     = 4'd8;
    localparam logic [LB_W-1:0] SET4_WBITS = 4'd2;

    typedef struct packed {
        logic [1:0]      assoc_mode;
        logic            replace_policy;
        logic [3:0]      offset_bits;
        logic [LB_W-1:0] line_bits;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]   ways;
        logic [RANK_W-1:0]  last_rank;   // ways - 1, also the way mask
        logic [LB_W-1:0]    way_bits;
    } layout_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              valid;
        logic [RANK_W-1:0] rank;
    } entry_t;

endpackage
`default_nettype wire

@@ src/ctsf_layout.sv @@
// ----------------------------------------------------------------------------
// ctsf_layout
// Derives set geometry from the configuration and splits an address into
// set base line and tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ctsf_layout (
    input  wire ctsf_pkg::cfg_t             cfg,
    input  wire logic [ctsf_pkg::ADDR_W-1:0] address,
    output ctsf_pkg::layout_t               lay,
    output logic [ctsf_pkg::LINE_AW-1:0]    base,
    output logic [ctsf_pkg::TAG_W-1:0]      tag
);
    import ctsf_pkg::*;

    logic [LB_W-1:0]    lb;
    logic [LB_W-1:0]    wb;
    logic [LB_W-1:0]    sb;
    logic [ADDR_W-1:0]  blk;
    logic [LINE_AW-1:0] set_idx;
    logic [CNT_W-1:0]   ways;
    logic [CNT_W-1:0]   set_mask;

    always_comb
    begin
        lb = cfg.line_bits;
        if (lb < LB_MIN)
            lb = LB_MIN;
        if (lb > LB_MAX)
            lb = LB_MAX;
        unique case (cfg.assoc_mode)
            MODE_DIRECT:
            begin
                wb = '0;
                sb = lb;
            end
            MODE_SET4:
            begin
                wb = SET4_WBITS;
                sb = lb - SET4_WBITS;
            end
            default:
            begin
                wb = lb;
                sb = '0;
            end
        endcase
        ways     = CNT_W'(1) << wb;
        set_mask = (CNT_W'(1) << sb) - CNT_W'(1);
        blk      = address >> cfg.offset_bits;
        tag      = blk >> sb;
        set_idx  = blk[LINE_AW-1:0] & set_mask[LINE_AW-1:0];
        base     = set_idx << wb;
        lay.ways      = ways;
        lay.last_rank = RANK_W'(ways - CNT_W'(1));
        lay.way_bits  = wb;
    end

endmodule
`default_nettype wire

@@ src/cache_tag_store_fifo_lru.sv @@
// Inputs are handled one at a time, W = ways per set
//   (1 direct-mapped, 4 set associative, up to 256 fully associative).
// The set is scanned one entry per cycle through the line memory, then
//   rewritten the same way after a decide step.
// Reset and every configuration write to indexes 0..3 start a clearing pass
//   over the whole line memory; no input is taken during it.
// ----------------------------------------------------------------------------
// cache_tag_store_fifo_lru
// Tag store with direct, 4-way or fully associative lookup and FIFO or LRU
// replacement, kept in one line memory with read-modify-write passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cache_tag_store_fifo_lru (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ctsf_pkg::ADDR_W-1:0] byte_address,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             hit,
    output logic                             evicted,
    output logic [ctsf_pkg::TAG_W-1:0]       evicted_tag,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [7:0]                  cfg_data
);
    import ctsf_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [1:0] RK_KEEP  = 2'd0;
    localparam logic [1:0] RK_FRONT = 2'd1;
    localparam logic [1:0] RK_BACK  = 2'd2;

    cfg_t                cfg_reg;
    logic [2:0]          state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                pend_reg;
    logic [LINE_AW-1:0]  pend_way_reg;
    logic [ADDR_W-1:0]   addr_reg;

    logic                hit_found_reg;
    logic [LINE_AW-1:0]  hit_way_reg;
    logic [RANK_W-1:0]   hit_rank_reg;
    logic                inv_found_reg;
    logic [LINE_AW-1:0]  inv_way_reg;
    logic [RANK_W-1:0]   inv_rank_reg;
    logic [LINE_AW-1:0]  r0_way_reg;
    logic [TAG_W-1:0]    r0_tag_reg;
    logic [LINE_AW-1:0]  rl_way_reg;
    logic [TAG_W-1:0]    rl_tag_reg;

    logic [LINE_AW-1:0]  tgt_way_reg;
    logic [RANK_W-1:0]   tgt_rank_reg;
    logic                wr_tgt_reg;
    logic [1:0]          rank_op_reg;
    logic                res_hit_reg;
    logic                res_ev_reg;
    logic [TAG_W-1:0]    res_tag_reg;

    logic                out_valid_reg;
    logic                hit_reg;
    logic                evicted_reg;
    logic [TAG_W-1:0]    evicted_tag_reg;

    entry_t              mem [NUM_LINES];
    entry_t              rd_data_reg;
    logic                mem_we;
    logic [LINE_AW-1:0]  mem_wa;
    logic [LINE_AW-1:0]  mem_ra;
    entry_t              mem_wd;
    entry_t              upd_entry;

    layout_t             lay;
    logic [LINE_AW-1:0]  base;
    logic [TAG_W-1:0]    tag;
    logic                issue;

    ctsf_layout u_layout (
        .cfg     (cfg_reg),
        .address (addr_reg),
        .lay     (lay),
        .base    (base),
        .tag     (tag)
    );

    // hold off lookups while a register write is offered
    assign in_ready    = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign evicted     = evicted_reg;
    assign evicted_tag = evicted_tag_reg;
    assign issue       = (cnt_reg < lay.ways);

    // rewrite of one way during the update pass
    always_comb
    begin
        upd_entry = rd_data_reg;
        unique case (rank_op_reg)
            RK_FRONT:
            begin
                if (pend_way_reg == tgt_way_reg)
                    upd_entry.rank = '0;
                else if (rd_data_reg.rank < tgt_rank_reg)
                    upd_entry.rank = rd_data_reg.rank + RANK_W'(1);
            end
            RK_BACK:
            begin
                if (pend_way_reg == tgt_way_reg)
                    upd_entry.rank = lay.last_rank;
                else if (rd_data_reg.rank > tgt_rank_reg)
                    upd_entry.rank = rd_data_reg.rank - RANK_W'(1);
            end
            default:
            begin
                upd_entry.rank = rd_data_reg.rank;
            end
        endcase
        if (wr_tgt_reg && pend_way_reg == tgt_way_reg)
        begin
            upd_entry.tag   = tag;
            upd_entry.valid = 1'b1;
        end
    end

    always_comb
    begin
        mem_ra = base + cnt_reg[LINE_AW-1:0];
        mem_we = 1'b0;
        mem_wa = base + pend_way_reg;
        mem_wd = upd_entry;
        if (state_reg == S_CLEAR)
        begin
            mem_we       = 1'b1;
            mem_wa       = cnt_reg[LINE_AW-1:0];
            mem_wd.tag   = '0;
            mem_wd.valid = 1'b0;
            mem_wd.rank  = cnt_reg[LINE_AW-1:0] & lay.last_rank;
        end
        else if (state_reg == S_UPD && pend_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            addr_reg <= byte_address;
        if (state_reg == S_SCAN && pend_reg)
        begin
            if (rd_data_reg.valid)
            begin
                if (!hit_found_reg && rd_data_reg.tag == tag)
                begin
                    hit_way_reg  <= pend_way_reg;
                    hit_rank_reg <= rd_data_reg.rank;
                end
            end
            else if (!inv_found_reg || rd_data_reg.rank < inv_rank_reg)
            begin
                inv_way_reg  <= pend_way_reg;
                inv_rank_reg <= rd_data_reg.rank;
            end
            if (rd_data_reg.rank == '0)
            begin
                r0_way_reg <= pend_way_reg;
                r0_tag_reg <= rd_data_reg.tag;
            end
            if (rd_data_reg.rank == lay.last_rank)
            begin
                rl_way_reg <= pend_way_reg;
                rl_tag_reg <= rd_data_reg.tag;
            end
        end
        if (state_reg == S_DECIDE)
        begin
            res_hit_reg <= 1'b0;
            res_ev_reg  <= 1'b0;
            res_tag_reg <= '0;
            wr_tgt_reg  <= 1'b1;
            rank_op_reg <= cfg_reg.replace_policy ? RK_FRONT : RK_KEEP;
            priority if (hit_found_reg)
            begin
                res_hit_reg  <= 1'b1;
                wr_tgt_reg   <= 1'b0;
                tgt_way_reg  <= hit_way_reg;
                tgt_rank_reg <= hit_rank_reg;
            end
            else if (inv_found_reg)
            begin
                tgt_way_reg  <= inv_way_reg;
                tgt_rank_reg <= inv_rank_reg;
            end
            else if (cfg_reg.replace_policy)
            begin
                res_ev_reg   <= 1'b1;
                res_tag_reg  <= rl_tag_reg;
                tgt_way_reg  <= rl_way_reg;
                tgt_rank_reg <= lay.last_rank;
            end
            else
            begin
                res_ev_reg   <= 1'b1;
                res_tag_reg  <= r0_tag_reg;
                tgt_way_reg  <= r0_way_reg;
                tgt_rank_reg <= '0;
                rank_op_reg  <= RK_BACK;
            end
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            hit_reg         <= res_hit_reg;
            evicted_reg     <= res_ev_reg;
            evicted_tag_reg <= res_tag_reg;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_way_reg  <= '0;
            hit_found_reg <= 1'b0;
            inv_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.assoc_mode     <= MODE_DIRECT;
            cfg_reg.replace_policy <= 1'b0;
            cfg_reg.offset_bits    <= 4'd4;
            cfg_reg.line_bits      <= 4'd8;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg[LINE_AW-1:0] == LINE_AW'(NUM_LINES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cnt_reg       <= '0;
                        pend_reg      <= 1'b0;
                        hit_found_reg <= 1'b0;
                        inv_found_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN, S_UPD:
                begin
                    pend_reg     <= issue;
                    pend_way_reg <= cnt_reg[LINE_AW-1:0];
                    if (issue)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    if (state_reg == S_SCAN && pend_reg)
                    begin
                        if (rd_data_reg.valid && rd_data_reg.tag == tag)
                            hit_found_reg <= 1'b1;
                        if (!rd_data_reg.valid)
                            inv_found_reg <= 1'b1;
                    end
                    if (!issue)
                        state_reg <= (state_reg == S_SCAN) ? S_DECIDE : S_DONE;
                end
                S_DECIDE:
                begin
                    cnt_reg   <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= S_UPD;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
            // a write to any defined register index (0..3) flushes the store
            if (cfg_valid && cfg_index <= CFG_LINES)
            begin
                unique case (cfg_index)
                    CFG_ASSOC:  cfg_reg.assoc_mode     <= cfg_data[1:0];
                    CFG_POLICY: cfg_reg.replace_policy <= cfg_data[0];
                    CFG_OFFSET: cfg_reg.offset_bits    <= cfg_data[3:0];
                    default:    cfg_reg.line_bits      <= cfg_data[3:0];
                endcase
                cnt_reg   <= '0;
                state_reg <= S_CLEAR;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/ctsf_checker.sv @@
// ----------------------------------------------------------------------------
// ctsf_checker
// Port-level checks on the result channel of the tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ctsf_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        hit,
    input wire logic                        evicted,
    input wire logic [ctsf_pkg::TAG_W-1:0]  evicted_tag
);
    import ctsf_pkg::*;

    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted) |-> (evicted_tag == '0))
        else $error("evicted_tag nonzero without eviction");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit and eviction reported together");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(evicted)))
        else $error("stalled result changed");

endmodule

bind cache_tag_store_fifo_lru ctsf_checker u_ctsf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .evicted     (evicted),
    .evicted_tag (evicted_tag)
);
`default_nettype wire
